@@ rtl/assert_macros.svh @@
// Assertion macros shared by the solver RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset
`define CLS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

// Consequent holds in the same cycle as the antecedent
`define CLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Consequent holds in the cycle after the antecedent
`define CLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ rtl/cls_pkg.sv @@
// Constants, permutation tables and command/status types for the solver.
// No dependencies; used by the controller, datapath and top level.
package cls_pkg;

    // System size and field widths
    localparam int ORDER    = 3;
    localparam int ENTRIES  = ORDER * (ORDER + 1);
    localparam int ENTRY_W  = 12;
    localparam int DET_W    = 50;
    localparam int SOL_W    = 48;
    localparam int FRAC_W   = 16;
    localparam int IDX_W    = 2;
    localparam int NUM_W    = DET_W + FRAC_W;
    localparam int PROD_W   = ENTRY_W * ORDER;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ROW_W    = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int DIV_CW   = $clog2(NUM_W);
    localparam int IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_BITS    = IDX_W + SOL_W + DET_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    // Determinant pipeline depth after the last read request
    localparam int DRAIN_CYC = 3;

    function automatic int fact(input int n);
        int f;
        f = 1;
        for (int i = 2; i <= n; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    localparam int NPERM  = fact(ORDER);
    localparam int PERM_W = (NPERM > 1) ? $clog2(NPERM) : 1;

    typedef logic [NPERM-1:0][ORDER-1:0][1:0] perm_cols_t;
    typedef logic [NPERM-1:0]                 perm_neg_t;

    // Column picked in each row by each permutation (Leibniz expansion)
    function automatic perm_cols_t build_cols();
        perm_cols_t tab;
        int         n;
        int         d [ORDER];
        bit         ok;
        tab = '0;
        n   = 0;
        for (int t = 0; t < (1 << (2 * ORDER)); t++) begin
            ok = 1'b1;
            for (int i = 0; i < ORDER; i++) begin
                d[i] = (t >> (2 * i)) & 3;
                if (d[i] >= ORDER) ok = 1'b0;
            end
            for (int i = 0; i < ORDER; i++) begin
                for (int j = i + 1; j < ORDER; j++) begin
                    if (d[i] == d[j]) ok = 1'b0;
                end
            end
            if (ok && n < NPERM) begin
                for (int i = 0; i < ORDER; i++) begin
                    tab[n][i] = 2'(d[i]);
                end
                n++;
            end
        end
        return tab;
    endfunction

    // Odd permutations contribute negatively
    function automatic perm_neg_t build_neg();
        perm_neg_t tab;
        int        n;
        int        inv;
        int        d [ORDER];
        bit        ok;
        tab = '0;
        n   = 0;
        for (int t = 0; t < (1 << (2 * ORDER)); t++) begin
            ok  = 1'b1;
            inv = 0;
            for (int i = 0; i < ORDER; i++) begin
                d[i] = (t >> (2 * i)) & 3;
                if (d[i] >= ORDER) ok = 1'b0;
            end
            for (int i = 0; i < ORDER; i++) begin
                for (int j = i + 1; j < ORDER; j++) begin
                    if (d[i] == d[j]) ok = 1'b0;
                    if (d[i] > d[j]) inv++;
                end
            end
            if (ok && n < NPERM) begin
                tab[n] = inv[0];
                n++;
            end
        end
        return tab;
    endfunction

    localparam perm_cols_t PERM_COL = build_cols();
    localparam perm_neg_t  PERM_NEG = build_neg();

    // Saturation bounds of the Q31.16 result, as quotient magnitudes
    localparam logic [NUM_W-1:0] SOL_POS_LIM = {{(NUM_W-SOL_W+1){1'b0}}, {(SOL_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] SOL_NEG_LIM = SOL_POS_LIM + NUM_W'(1);

    // Controller to datapath commands
    typedef struct packed {
        logic             acc_clr;
        logic             rd_valid;
        logic             rd_first;
        logic             rd_last;
        logic             rd_neg;
        logic             store_main;
        logic             div_start;
        logic             div_step;
        logic             emit;
        logic             emit_sing;
        logic             emit_last;
        logic [IDX_W-1:0] emit_index;
    } cls_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic main_zero;
        logic out_free;
    } cls_sts_t;

endpackage

@@ rtl/cls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cls_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/cls_ctrl.sv @@
// Solver sequencer: load, determinant read schedule, division and result steps.
// Depends on cls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cls_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    output logic                      wr_en,
    output logic [cls_pkg::ADDR_W-1:0] wr_addr,
    output logic [cls_pkg::ADDR_W-1:0] rd_addr,
    output cls_pkg::cls_cmd_t         cmd,
    input  cls_pkg::cls_sts_t         sts
);
    import cls_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_SING  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [PERM_W-1:0] perm_reg, perm_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              repl_reg, repl_next;
    logic [1:0]        drain_reg, drain_next;
    logic [DIV_CW-1:0] div_reg, div_next;

    logic [1:0]        col;
    int                eff_col;

    // Read address: entry of the current permutation, column k swapped for b
    always_comb
    begin
        col     = PERM_COL[perm_reg][row_reg];
        eff_col = (repl_reg && (col == k_reg)) ? ORDER : int'(col);
        rd_addr = ADDR_W'(int'(row_reg) * (ORDER + 1) + eff_col);
    end

    assign wr_addr  = cnt_reg;
    assign s_tready = (state_reg == S_LOAD);
    assign wr_en    = s_tready && s_tvalid;

    // Next-state and command logic
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        perm_next  = perm_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        repl_next  = repl_reg;
        drain_next = drain_reg;
        div_next   = div_reg;
        cmd        = '0;
        cmd.rd_first   = (row_reg == '0);
        cmd.rd_last    = (row_reg == ROW_W'(ORDER - 1));
        cmd.rd_neg     = PERM_NEG[perm_reg];
        cmd.emit_index = k_reg;
        cmd.emit_last  = (k_reg == IDX_W'(ORDER - 1));

        case (state_reg)
            S_LOAD:
            begin
                if (wr_en)
                begin
                    if (cnt_reg == ADDR_W'(ENTRIES - 1))
                    begin
                        cnt_next    = '0;
                        repl_next   = 1'b0;
                        perm_next   = '0;
                        row_next    = '0;
                        cmd.acc_clr = 1'b1;
                        state_next  = S_ISSUE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + ADDR_W'(1);
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.rd_valid = 1'b1;
                if (row_reg == ROW_W'(ORDER - 1))
                begin
                    row_next = '0;
                    if (perm_reg == PERM_W'(NPERM - 1))
                    begin
                        perm_next  = '0;
                        drain_next = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        perm_next = perm_reg + PERM_W'(1);
                    end
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == 2'(DRAIN_CYC - 1))
                begin
                    if (repl_reg)
                    begin
                        cmd.div_start = 1'b1;
                        div_next      = '0;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.store_main = 1'b1;
                        state_next     = S_CHECK;
                    end
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            S_CHECK:
            begin
                if (sts.main_zero)
                begin
                    state_next = S_SING;
                end
                else
                begin
                    k_next      = '0;
                    repl_next   = 1'b1;
                    cmd.acc_clr = 1'b1;
                    state_next  = S_ISSUE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_reg == DIV_CW'(NUM_W - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    div_next = div_reg + DIV_CW'(1);
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (k_reg == IDX_W'(ORDER - 1))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next      = k_reg + IDX_W'(1);
                        cmd.acc_clr = 1'b1;
                        state_next  = S_ISSUE;
                    end
                end
            end
            S_SING:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sing = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            perm_reg  <= '0;
            row_reg   <= '0;
            k_reg     <= '0;
            repl_reg  <= 1'b0;
            drain_reg <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            perm_reg  <= perm_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            repl_reg  <= repl_next;
            drain_reg <= drain_next;
            div_reg   <= div_next;
        end
    end

    `CLS_ASSERT(a_cnt_range, cnt_reg < ADDR_W'(ENTRIES))
    `CLS_ASSERT_IMP(a_emit_free, cmd.emit || cmd.emit_sing, sts.out_free)
    `CLS_ASSERT_NXT(a_sing_reload, cmd.emit_sing, state_reg == S_LOAD)

endmodule

@@ rtl/cls_dpath.sv @@
// Solver datapath: product/accumulate unit, restoring divider, output register.
// Depends on cls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cls_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cls_pkg::cls_cmd_t              cmd,
    output cls_pkg::cls_sts_t              sts,
    input  logic [cls_pkg::ENTRY_W-1:0]    rd_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cls_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import cls_pkg::*;

    // Read-alignment stage
    logic v1_reg, first1_reg, last1_reg, neg1_reg;
    // Product stage
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     pend2_reg, neg2_reg;
    // Accumulator and main determinant
    logic signed [DET_W-1:0]  acc_reg, acc_next;
    logic signed [DET_W-1:0]  main_det_reg;
    // Divider
    logic [DET_W-1:0]  rem_reg, dsr_reg;
    logic [NUM_W-1:0]  num_reg, quo_reg;
    logic              qneg_reg;
    logic [DET_W:0]    rem_sh;
    logic              ge;
    logic [DET_W:0]    rem_sub;
    logic [DET_W-1:0]  acc_mag, main_mag;
    // Result shaping
    logic [NUM_W-1:0]  lim;
    logic [SOL_W-1:0]  mag_s;
    logic [SOL_W-1:0]  sol_val;
    // Output register
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [SOL_W-1:0]  out_sol_reg;
    logic [DET_W-1:0]  out_det_reg;
    logic              out_sing_reg, out_last_reg;

    logic signed [PROD_W+ENTRY_W-1:0] mul_full;
    logic signed [ENTRY_W-1:0]        entry_s;

    assign entry_s  = signed'(rd_data);
    assign mul_full = prod_reg * entry_s;

    // Product of one permutation's entries, one factor per cycle
    always_comb
    begin
        prod_next = prod_reg;
        if (v1_reg)
        begin
            prod_next = first1_reg ? PROD_W'(entry_s) : mul_full[PROD_W-1:0];
        end
    end

    // Signed accumulate of finished products
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (pend2_reg)
        begin
            acc_next = neg2_reg ? acc_reg - DET_W'(prod_reg) : acc_reg + DET_W'(prod_reg);
        end
    end

    // Magnitudes for the divider and one restoring step
    always_comb
    begin
        acc_mag  = acc_reg[DET_W-1] ? DET_W'(-acc_reg) : DET_W'(acc_reg);
        main_mag = main_det_reg[DET_W-1] ? DET_W'(-main_det_reg) : DET_W'(main_det_reg);
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        ge       = (rem_sh >= {1'b0, dsr_reg});
    end

    // Saturate the quotient to Q31.16 and apply the sign
    always_comb
    begin
        lim     = qneg_reg ? SOL_NEG_LIM : SOL_POS_LIM;
        mag_s   = (quo_reg > lim) ? lim[SOL_W-1:0] : quo_reg[SOL_W-1:0];
        sol_val = qneg_reg ? SOL_W'(-mag_s) : mag_s;
    end

    // Pipeline, divider and output payload registers
    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.rd_first;
        last1_reg  <= cmd.rd_last;
        neg1_reg   <= cmd.rd_neg;
        prod_reg   <= prod_next;
        neg2_reg   <= neg1_reg;
        acc_reg    <= acc_next;
        if (cmd.div_start)
        begin
            num_reg  <= {acc_mag, {FRAC_W{1'b0}}};
            dsr_reg  <= main_mag;
            rem_reg  <= '0;
            quo_reg  <= '0;
            qneg_reg <= acc_reg[DET_W-1] ^ main_det_reg[DET_W-1];
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[DET_W-1:0] : rem_sh[DET_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
        if (cmd.emit || cmd.emit_sing)
        begin
            out_idx_reg  <= cmd.emit_sing ? '0 : cmd.emit_index;
            out_sol_reg  <= cmd.emit_sing ? '0 : sol_val;
            out_det_reg  <= cmd.emit_sing ? '0 : main_det_reg;
            out_sing_reg <= cmd.emit_sing;
            out_last_reg <= cmd.emit_sing | cmd.emit_last;
        end
    end

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            pend2_reg     <= 1'b0;
            main_det_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= cmd.rd_valid;
            pend2_reg <= v1_reg & last1_reg;
            if (cmd.store_main)
            begin
                main_det_reg <= acc_reg;
            end
            if (cmd.emit || cmd.emit_sing)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.main_zero = (main_det_reg == '0);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_det_reg, out_sol_reg, out_idx_reg};
    assign m_tuser  = out_sing_reg;
    assign m_tlast  = out_last_reg;

    `CLS_ASSERT_IMP(a_sing_last, m_tvalid && m_tuser, m_tlast && (out_det_reg == '0))
    `CLS_ASSERT_IMP(a_div_nonzero, cmd.div_start, main_det_reg != '0)

endmodule

@@ rtl/cramer_linear_solver.sv @@
// Channel | dir | tdata (low bit up)                           | tuser    | tlast
// s_      | in  | entry_value[11:0], zero pad to 16            | -        | -
// m_      | out | unknown_index[1:0], solution[49:2],           | singular | last_result
//         |     | system_determinant[99:50], zero pad to 104   |          |
// Loading takes one cycle per entry, ORDER*(ORDER+1) entries per system.
// The main determinant takes ORDER*ORDER! RAM reads (one entry per cycle
// through the single read port) and a drain of the determinant pipeline; each unknown
// adds the same reads and drain, 66 divider steps and one output result.
// Reset (rst_n low, asynchronous) returns to loading with the entry count at zero.
// A stalled output only holds the sequencer at its next result; loading resumes after it.
// Top level of the solver; depends on cls_pkg, cls_ram, cls_ctrl and cls_dpath.
module cramer_linear_solver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cls_pkg::IN_TDATA_W-1:0]  s_tdata,   // entry_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cls_pkg::OUT_TDATA_W-1:0] m_tdata,   // unknown_index, solution, system_determinant
    output logic                            m_tuser,   // singular
    output logic                            m_tlast    // last_result
);
    import cls_pkg::*;

    cls_cmd_t          cmd;
    cls_sts_t          sts;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // Matrix store
    cls_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[ENTRY_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer
    cls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Arithmetic and output register
    cls_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
